// ----- hw/rtl/force_spike_filter_progress_throttle_unit_assert.svh -----
// Assertion macros used by the force spike filter throttle top level.
`ifndef FORCE_SPIKE_FILTER_PROGRESS_THROTTLE_UNIT_ASSERT_SVH
`define FORCE_SPIKE_FILTER_PROGRESS_THROTTLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FSPT_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fspt: same-cycle implication violated");

// Next-cycle implication, disabled while reset is high.
`define FSPT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fspt: next-cycle implication violated");

`endif

// ----- hw/rtl/fspt_pkg.sv -----
// Package with types and constants of the force spike filter throttle unit.
`default_nettype none

package fspt_pkg;

   localparam int FORCE_W = 24;
   localparam int SCALE_W = 17;
   localparam int AGE_W   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Item kinds.
   localparam logic [1:0] MODE_SAMPLE = 2'd0;
   localparam logic [1:0] MODE_TICK   = 2'd1;
   localparam logic [1:0] MODE_TOGGLE = 2'd2;

   // Result status codes.
   localparam logic [2:0] STAT_DISABLED  = 3'd0;
   localparam logic [2:0] STAT_INACTIVE  = 3'd1;
   localparam logic [2:0] STAT_STALE     = 3'd2;
   localparam logic [2:0] STAT_HARD_HOLD = 3'd3;
   localparam logic [2:0] STAT_ERR_HOLD  = 3'd4;
   localparam logic [2:0] STAT_THROTTLE  = 3'd5;
   localparam logic [2:0] STAT_TRACKING  = 3'd6;
   localparam logic [2:0] STAT_OTHER     = 3'd7;

   // Register indexes.
   localparam logic [2:0] CSR_AXIS_SELECT   = 3'd0;
   localparam logic [2:0] CSR_ABSOLUTE_MODE = 3'd1;
   localparam logic [2:0] CSR_SPIKE_BAND    = 3'd2;
   localparam logic [2:0] CSR_CONFIRM       = 3'd3;
   localparam logic [2:0] CSR_HARD_LIMIT    = 3'd4;
   localparam logic [2:0] CSR_TARGET_FORCE  = 3'd5;
   localparam logic [2:0] CSR_FULL_SPEED    = 3'd6;
   localparam logic [2:0] CSR_PAUSE_ERROR   = 3'd7;

   localparam logic [SCALE_W-1:0] ONE_Q16   = 17'h10000;
   localparam logic [FORCE_W-1:0] FORCE_MAX = 24'h7FFFFF;
   localparam logic [FORCE_W-1:0] FORCE_MIN = 24'h800000;

   // Quotient bits produced by the restoring divider, one per step.
   localparam int            DIV_STEPS = 17;
   localparam int            DIV_CNT_W = 5;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_PREP,
      CTL_EXEC,
      CTL_MUL,
      CTL_DIV,
      CTL_EMIT
   } fspt_state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic exec;
      logic mul;
      logic div_step;
      logic emit;
   } fspt_cmd_type;

   typedef struct packed {
      logic need_div;
   } fspt_sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/fspt_req_if.sv -----
// Input channel interface of the force spike filter throttle unit.
`default_nettype none

interface fspt_req_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           mode;
   logic signed [23:0]   force_x;
   logic signed [23:0]   force_y;
   logic signed [23:0]   force_z;
   logic                 contact_task;
   logic                 enable_value;

   modport source (
      output valid, mode, force_x, force_y, force_z, contact_task, enable_value,
      input  ready
   );

   modport sink (
      input  valid, mode, force_x, force_y, force_z, contact_task, enable_value,
      output ready
   );
endinterface

`default_nettype wire

// ----- hw/rtl/fspt_rsp_if.sv -----
// Result channel interface of the force spike filter throttle unit.
`default_nettype none

interface fspt_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [16:0]          force_scale;
   logic [2:0]           status;
   logic signed [23:0]   measured_out;
   logic                 hard_stop_out;
   logic                 sample_taken;

   modport source (
      output valid, force_scale, status, measured_out, hard_stop_out, sample_taken,
      input  ready
   );

   modport sink (
      input  valid, force_scale, status, measured_out, hard_stop_out, sample_taken,
      output ready
   );
endinterface

`default_nettype wire

// ----- hw/rtl/fspt_ctrl.sv -----
// Controller state machine that sequences one item through the datapath.
`default_nettype none

module fspt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire fspt_pkg::fspt_sts_type sts,
   output fspt_pkg::fspt_cmd_type     cmd
);

   fspt_pkg::fspt_state_type state_ff, state_in;
   logic [fspt_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           out_free;
   logic                           div_last;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign div_last = (div_cnt_ff == fspt_pkg::DIV_CNT_W'(fspt_pkg::DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fspt_pkg::CTL_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fspt_pkg::CTL_IDLE: begin
            if (req_valid) state_in = fspt_pkg::CTL_PREP;
         end
         fspt_pkg::CTL_PREP: begin
            state_in = fspt_pkg::CTL_EXEC;
         end
         fspt_pkg::CTL_EXEC: begin
            state_in = sts.need_div ? fspt_pkg::CTL_MUL : fspt_pkg::CTL_EMIT;
         end
         fspt_pkg::CTL_MUL: begin
            state_in = fspt_pkg::CTL_DIV;
         end
         fspt_pkg::CTL_DIV: begin
            if (div_last) state_in = fspt_pkg::CTL_EMIT;
         end
         fspt_pkg::CTL_EMIT: begin
            if (out_free) state_in = fspt_pkg::CTL_IDLE;
         end
         default: begin
            state_in = fspt_pkg::CTL_IDLE;
         end
      endcase
   end

   // Outputs and commands.
   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         fspt_pkg::CTL_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         fspt_pkg::CTL_PREP: begin
            cmd.prep = 1'b1;
         end
         fspt_pkg::CTL_EXEC: begin
            cmd.exec = 1'b1;
         end
         fspt_pkg::CTL_MUL: begin
            cmd.mul    = 1'b1;
            div_cnt_in = '0;
         end
         fspt_pkg::CTL_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
         end
         fspt_pkg::CTL_EMIT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/fspt_datapath.sv -----
// Datapath: registers, spike filter, throttle multiply and restoring divider.
`default_nettype none

module fspt_datapath #(
   parameter int STALE_TICKS   = 20,
   parameter int MIN_SCALE_Q16 = 6554
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire fspt_pkg::fspt_cmd_type  cmd,
   output fspt_pkg::fspt_sts_type       sts,
   input  wire logic                    csr_we,
   input  wire logic [2:0]              csr_index,
   input  wire logic [23:0]             csr_wdata,
   input  wire logic [1:0]              req_mode,
   input  wire logic signed [23:0]      req_force_x,
   input  wire logic signed [23:0]      req_force_y,
   input  wire logic signed [23:0]      req_force_z,
   input  wire logic                    req_contact_task,
   input  wire logic                    req_enable_value,
   output logic [16:0]                  rsp_force_scale,
   output logic [2:0]                   rsp_status,
   output logic signed [23:0]           rsp_measured_out,
   output logic                         rsp_hard_stop_out,
   output logic                         rsp_sample_taken
);

   localparam int MIN_CLAMPED = (MIN_SCALE_Q16 < 0) ? 0 :
                                ((MIN_SCALE_Q16 > 65536) ? 65536 : MIN_SCALE_Q16);
   localparam logic [16:0] RAMP_SPAN = 17'(65536 - MIN_CLAMPED);
   localparam logic [15:0] STALE_LIMIT = 16'(STALE_TICKS);

   // Configuration registers.
   logic [1:0]          axis_ff;
   logic                absmode_ff;
   logic [22:0]         band_ff;
   logic [7:0]          confirm_ff;
   logic signed [23:0]  hard_ff;
   logic signed [23:0]  target_ff;
   logic [22:0]         fse_ff;
   logic [22:0]         pause_ff;

   // Filter state.
   logic signed [23:0]  measured_ff, measured_in;
   logic                seen_ff, seen_in;
   logic [7:0]          spike_cnt_ff, spike_cnt_in;
   logic                latch_ff, latch_in;
   logic                enabled_ff, enabled_in;
   logic [15:0]         age_ff, age_in;

   // Latched item.
   logic [1:0]          mode_ff;
   logic signed [23:0]  fx_ff, fy_ff, fz_ff;
   logic                contact_ff;
   logic                enval_ff;

   // Prepared operands.
   logic signed [23:0]  raw_ff;
   logic [24:0]         err_ff;
   logic [23:0]         pause_eff_ff;

   // Pending result and divider.
   logic [16:0]         res_scale_ff, res_scale_in;
   logic [2:0]          res_status_ff, res_status_in;
   logic                res_div_ff, res_div_in;
   logic                res_taken_ff, res_taken_in;
   logic [23:0]         mula_ff;
   logic [23:0]         dvs_ff;
   logic [23:0]         rem_ff;
   logic [16:0]         quo_ff;

   // Output register.
   logic [16:0]         out_scale_ff;
   logic [2:0]          out_status_ff;
   logic signed [23:0]  out_measured_ff;
   logic                out_stop_ff;
   logic                out_taken_ff;

   // Preparation stage signals.
   logic signed [23:0]  sel_force;
   logic signed [23:0]  raw_val;
   logic signed [24:0]  err_diff;
   logic [24:0]         err_mag;
   logic [23:0]         fse_plus;
   logic [23:0]         pause_eff;

   // Execute stage signals.
   logic signed [24:0]  jump_diff;
   logic [24:0]         jump_mag;
   logic                outlier;
   logic [7:0]          cnt_inc;
   logic [7:0]          need;
   logic                accept;
   logic [15:0]         age_inc;
   logic                stale;
   logic                e_ge_p;
   logic                e_le_f;
   logic                need_div;

   // Divider step.
   logic [24:0]         div_shift;
   logic                div_ge;
   logic [24:0]         div_sub;
   logic [40:0]         product;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff    <= 2'd2;
         absmode_ff <= 1'b1;
         band_ff    <= 23'd2048;
         confirm_ff <= 8'd3;
         hard_ff    <= 24'sd8960;
         target_ff  <= 24'sd3072;
         fse_ff     <= 23'd512;
         pause_ff   <= 23'd2048;
      end else if (csr_we) begin
         case (csr_index)
            fspt_pkg::CSR_AXIS_SELECT:   axis_ff    <= csr_wdata[1:0];
            fspt_pkg::CSR_ABSOLUTE_MODE: absmode_ff <= csr_wdata[0];
            fspt_pkg::CSR_SPIKE_BAND:    band_ff    <= csr_wdata[22:0];
            fspt_pkg::CSR_CONFIRM:       confirm_ff <= csr_wdata[7:0];
            fspt_pkg::CSR_HARD_LIMIT:    hard_ff    <= $signed(csr_wdata);
            fspt_pkg::CSR_TARGET_FORCE:  target_ff  <= $signed(csr_wdata);
            fspt_pkg::CSR_FULL_SPEED:    fse_ff     <= csr_wdata[22:0];
            fspt_pkg::CSR_PAUSE_ERROR:   pause_ff   <= csr_wdata[22:0];
            default:                     axis_ff    <= axis_ff;
         endcase
      end
   end

   // Preparation: select the axis, fold to magnitude, form the force error.
   always_comb begin
      case (axis_ff)
         2'd0:    sel_force = fx_ff;
         2'd1:    sel_force = fy_ff;
         default: sel_force = fz_ff;
      endcase
      raw_val = sel_force;
      if (absmode_ff && sel_force[23]) begin
         raw_val = (sel_force == $signed(fspt_pkg::FORCE_MIN)) ?
                   $signed(fspt_pkg::FORCE_MAX) : -sel_force;
      end
      err_diff  = 25'(measured_ff) - 25'(target_ff);
      err_mag   = err_diff[24] ? 25'(-err_diff) : 25'(err_diff);
      fse_plus  = {1'b0, fse_ff} + 24'd1;
      pause_eff = ({1'b0, pause_ff} > fse_plus) ? {1'b0, pause_ff} : fse_plus;
   end

   // Execute: spike test and tick classification.
   always_comb begin
      jump_diff = 25'(raw_ff) - 25'(measured_ff);
      jump_mag  = jump_diff[24] ? 25'(-jump_diff) : 25'(jump_diff);
      outlier   = seen_ff && (jump_mag > {2'b00, band_ff});
      cnt_inc   = (spike_cnt_ff == 8'hFF) ? spike_cnt_ff : spike_cnt_ff + 8'd1;
      need      = (confirm_ff == 8'd0) ? 8'd1 : confirm_ff;
      accept    = !outlier || (cnt_inc >= need);
      age_inc   = (age_ff == 16'hFFFF) ? age_ff : age_ff + 16'd1;
      stale     = !seen_ff || (age_inc > STALE_LIMIT);
      e_ge_p    = err_ff >= {1'b0, pause_eff_ff};
      e_le_f    = err_ff <= {2'b00, fse_ff};
      need_div  = (mode_ff == fspt_pkg::MODE_TICK) && enabled_ff && contact_ff &&
                  !stale && !latch_ff && !e_ge_p && !e_le_f;
   end

   assign sts.need_div = need_div;

   always_comb begin
      measured_in   = measured_ff;
      seen_in       = seen_ff;
      spike_cnt_in  = spike_cnt_ff;
      latch_in      = latch_ff;
      enabled_in    = enabled_ff;
      age_in        = age_ff;
      res_scale_in  = '0;
      res_status_in = fspt_pkg::STAT_OTHER;
      res_div_in    = 1'b0;
      res_taken_in  = 1'b0;
      case (mode_ff)
         fspt_pkg::MODE_SAMPLE: begin
            spike_cnt_in = outlier ? cnt_inc : 8'd0;
            if (accept) begin
               measured_in  = raw_ff;
               seen_in      = 1'b1;
               age_in       = '0;
               res_taken_in = 1'b1;
               if (enabled_ff && (raw_ff >= hard_ff)) latch_in = 1'b1;
            end
         end
         fspt_pkg::MODE_TICK: begin
            age_in = age_inc;
            if (!enabled_ff) begin
               res_scale_in  = fspt_pkg::ONE_Q16;
               res_status_in = fspt_pkg::STAT_DISABLED;
            end else if (!contact_ff) begin
               res_scale_in  = fspt_pkg::ONE_Q16;
               res_status_in = fspt_pkg::STAT_INACTIVE;
            end else if (stale) begin
               res_status_in = fspt_pkg::STAT_STALE;
            end else if (latch_ff) begin
               res_status_in = fspt_pkg::STAT_HARD_HOLD;
            end else if (e_ge_p) begin
               res_status_in = fspt_pkg::STAT_ERR_HOLD;
            end else if (e_le_f) begin
               res_scale_in  = fspt_pkg::ONE_Q16;
               res_status_in = fspt_pkg::STAT_TRACKING;
            end else begin
               res_div_in = 1'b1;
            end
         end
         fspt_pkg::MODE_TOGGLE: begin
            enabled_in   = enval_ff;
            latch_in     = 1'b0;
            seen_in      = 1'b0;
            spike_cnt_in = '0;
         end
         default: begin
            res_status_in = fspt_pkg::STAT_OTHER;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         measured_ff  <= '0;
         seen_ff      <= 1'b0;
         spike_cnt_ff <= '0;
         latch_ff     <= 1'b0;
         enabled_ff   <= 1'b0;
         age_ff       <= '0;
      end else if (cmd.exec) begin
         measured_ff  <= measured_in;
         seen_ff      <= seen_in;
         spike_cnt_ff <= spike_cnt_in;
         latch_ff     <= latch_in;
         enabled_ff   <= enabled_in;
         age_ff       <= age_in;
      end
   end

   // The ratio numerator stays below divisor * 2^16, so its upper bits
   // start the remainder and only the low 17 bits need shifting in.
   assign product   = 41'(mula_ff) * 41'(RAMP_SPAN);
   assign div_shift = {rem_ff, quo_ff[16]};
   assign div_ge    = div_shift >= {1'b0, dvs_ff};
   assign div_sub   = div_shift - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= req_mode;
         fx_ff      <= req_force_x;
         fy_ff      <= req_force_y;
         fz_ff      <= req_force_z;
         contact_ff <= req_contact_task;
         enval_ff   <= req_enable_value;
      end
      if (cmd.prep) begin
         raw_ff       <= raw_val;
         err_ff       <= err_mag;
         pause_eff_ff <= pause_eff;
      end
      if (cmd.exec) begin
         res_scale_ff  <= res_scale_in;
         res_status_ff <= res_status_in;
         res_div_ff    <= res_div_in;
         res_taken_ff  <= res_taken_in;
         mula_ff       <= err_ff[23:0] - {1'b0, fse_ff};
         dvs_ff        <= pause_eff_ff - {1'b0, fse_ff};
      end
      if (cmd.mul) begin
         rem_ff <= product[40:17];
         quo_ff <= product[16:0];
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? div_sub[23:0] : div_shift[23:0];
         quo_ff <= {quo_ff[15:0], div_ge};
      end
      if (cmd.emit) begin
         out_scale_ff    <= res_div_ff ? (fspt_pkg::ONE_Q16 - quo_ff) : res_scale_ff;
         out_status_ff   <= res_div_ff ?
                            ((quo_ff != '0) ? fspt_pkg::STAT_THROTTLE : fspt_pkg::STAT_TRACKING) :
                            res_status_ff;
         out_measured_ff <= measured_ff;
         out_stop_ff     <= latch_ff;
         out_taken_ff    <= res_taken_ff;
      end
   end

   assign rsp_force_scale   = out_scale_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_measured_out  = out_measured_ff;
   assign rsp_hard_stop_out = out_stop_ff;
   assign rsp_sample_taken  = out_taken_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/force_spike_filter_progress_throttle_unit.sv -----
// Top level of the force spike filter and progress throttle unit.
`default_nettype none
// Usage: items arrive on req_port (valid/ready); each item gives exactly one
// result item on rsp_port. A sample item filters one force axis against the
// spike band, a tick item ages the sample and yields a progress speed scale,
// and a toggle item sets the enable and clears the stop latch and filter.
// Registers are written through csr_we/csr_index/csr_wdata while idle.
// One item is processed at a time. Sample, toggle and untrottled tick items
// pass from acceptance through the prepare, execute and emit states to a
// valid result; a tick on the throttle ramp also passes the multiplier and
// the restoring divider that forms the ramp ratio one quotient bit a step.
// A new item is accepted once the previous one has reached the output
// register, so a stalled receiver holds one finished result while the next
// item is taken in; that next result then waits until the output register
// is free. A synchronous active-high reset returns the filter state and the
// registers to their reset values and empties the output register.
// STALE_TICKS is the tick count after which a sample is stale, and
// MIN_SCALE_Q16 the scale reached just before the pause error.

module force_spike_filter_progress_throttle_unit #(
   parameter int STALE_TICKS   = 20,
   parameter int MIN_SCALE_Q16 = 6554
) (
   input  wire logic         clock,
   input  wire logic         reset,
   fspt_req_if.sink          req_port,
   fspt_rsp_if.source        rsp_port,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [23:0]  csr_wdata
);

   fspt_pkg::fspt_cmd_type cmd;
   fspt_pkg::fspt_sts_type sts;
   logic                   req_ready;
   logic                   rsp_valid;

   // The controller sequences the item; the datapath holds the filter, register and result state.
   fspt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_port.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fspt_datapath #(
      .STALE_TICKS   (STALE_TICKS),
      .MIN_SCALE_Q16 (MIN_SCALE_Q16)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_mode          (req_port.mode),
      .req_force_x       (req_port.force_x),
      .req_force_y       (req_port.force_y),
      .req_force_z       (req_port.force_z),
      .req_contact_task  (req_port.contact_task),
      .req_enable_value  (req_port.enable_value),
      .rsp_force_scale   (rsp_port.force_scale),
      .rsp_status        (rsp_port.status),
      .rsp_measured_out  (rsp_port.measured_out),
      .rsp_hard_stop_out (rsp_port.hard_stop_out),
      .rsp_sample_taken  (rsp_port.sample_taken)
   );

   assign req_port.ready = req_ready;
   assign rsp_port.valid = rsp_valid;

   `include "force_spike_filter_progress_throttle_unit_assert.svh"

   // Only one item is in flight: an accepted item blocks the input next cycle.
   `FSPT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_port.valid && req_ready, !req_ready)
   // The output register is loaded only when it is empty or being drained.
   `FSPT_ASSERT_IMPLY(a_emit_free, clock, reset, cmd.emit, !rsp_valid || rsp_port.ready)
   // A throttled scale lies strictly between zero and one.
   `FSPT_ASSERT_IMPLY(a_throttle_range, clock, reset, rsp_valid && (rsp_port.status == fspt_pkg::STAT_THROTTLE), (rsp_port.force_scale != 17'd0) && !rsp_port.force_scale[16])
   // A hard hold is reported only with the stop latch set.
   `FSPT_ASSERT_IMPLY(a_hold_latched, clock, reset, rsp_valid && (rsp_port.status == fspt_pkg::STAT_HARD_HOLD), rsp_port.hard_stop_out)

endmodule

`default_nettype wire

// ----- sim/tb_force_spike_filter_progress_throttle_unit.sv -----
// Self-checking testbench of the force spike filter and progress throttle unit.
`default_nettype none

module tb_force_spike_filter_progress_throttle_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import fspt_pkg::*;

   // The block is built with its default ramp floor and stale limit, and the
   // prediction below uses the same values.
   localparam int STALE_TICKS = 20;
   localparam int MIN_SCALE   = 6554;

   // A sample or toggle may sit behind a ramp tick in the divider, and either
   // side may hold off at random, so WATCHDOG_LIMIT quiet cycles mean a hang.
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned DRAIN_CYCLES   = 30;

   // Mode three is not used by the block; it must still give a plain result.
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // Axis select codes. Code three falls back to the z component.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;
   localparam logic [1:0] AXIS_Z_ALIAS = 2'd3;

   localparam longint FORCE_TOP = 8388607;
   localparam longint FORCE_BOTTOM = -8388608;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [23:0] force_x;
      logic signed [23:0] force_y;
      logic signed [23:0] force_z;
      logic               contact_task;
      logic               enable_value;
   } force_item_t;

   typedef struct packed {
      logic [16:0]        force_scale;
      logic [2:0]         status;
      logic signed [23:0] measured;
      logic               hard_stop;
      logic               taken;
   } throttle_result_t;

   // A directed row carries its item and, where the answer is obvious, the
   // result typed in by hand. Other rows are checked against the predictor.
   typedef struct packed {
      force_item_t      item;
      logic             pinned;
      throttle_result_t want;
   } directed_row_t;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [2:0] csr_index;
   logic [23:0] csr_wdata;

   fspt_req_if req_bus ();
   fspt_rsp_if rsp_bus ();

   force_spike_filter_progress_throttle_unit #(
      .STALE_TICKS   (STALE_TICKS),
      .MIN_SCALE_Q16 (MIN_SCALE)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Register copies kept by the predictor.
   logic [1:0]         cfg_axis;
   logic               cfg_magnitude;
   logic [22:0]        cfg_band;
   logic [7:0]         cfg_confirm;
   logic signed [23:0] cfg_hard_limit;
   logic signed [23:0] cfg_target;
   logic [22:0]        cfg_full_err;
   logic [22:0]        cfg_pause_err;

   // Filter and throttle state kept by the predictor.
   logic signed [23:0] filt_meas;
   logic               filt_seen;
   logic [7:0]         outlier_run;
   logic               stop_held;
   logic               ctl_enabled;
   logic [15:0]        ticks_since_sample;

   throttle_result_t pending_results[$];
   directed_row_t    stim_rows[$];

   bit          started = 1'b0;
   bit          idle_on = 1'b1;
   int unsigned items_sent = 0;
   int unsigned mismatches = 0;
   int unsigned settings_used = 0;
   int unsigned mode_counts[4];
   int unsigned status_counts[8];

   task automatic load_reset_state();
      cfg_axis = AXIS_Z;
      cfg_magnitude = 1'b1;
      cfg_band = 23'd2048;
      cfg_confirm = 8'd3;
      cfg_hard_limit = 24'sd8960;
      cfg_target = 24'sd3072;
      cfg_full_err = 23'd512;
      cfg_pause_err = 23'd2048;
      filt_meas = '0;
      filt_seen = 1'b0;
      outlier_run = '0;
      stop_held = 1'b0;
      ctl_enabled = 1'b0;
      ticks_since_sample = '0;
   endtask

   // The pause error is never allowed to fall to or below the full-speed error.
   function automatic longint eff_pause();
      longint f;
      f = cfg_full_err;
      return (longint'(cfg_pause_err) > f + 1) ? longint'(cfg_pause_err) : f + 1;
   endfunction

   // Predicts the result of one item and advances the predictor's state.
   function automatic throttle_result_t qualify_and_throttle(input force_item_t it);
      throttle_result_t r;
      longint raw, jump, f, p, e, m, term;
      int unsigned need;
      bit accept;
      r = '0;
      r.status = STAT_OTHER;
      case (it.mode)
         MODE_SAMPLE: begin
            case (cfg_axis)
               AXIS_X: raw = $signed(it.force_x);
               AXIS_Y: raw = $signed(it.force_y);
               default: raw = $signed(it.force_z);
            endcase
            // The magnitude of the most negative force saturates.
            if (cfg_magnitude) begin
               if (raw < 0) raw = -raw;
               if (raw > FORCE_TOP) raw = FORCE_TOP;
            end
            jump = raw - longint'(filt_meas);
            if (jump < 0) jump = -jump;
            need = (cfg_confirm == 0) ? 1 : cfg_confirm;
            // Outliers are held back until enough of them arrive in a row;
            // once accepted, the run count stays so later outliers pass at once.
            if (filt_seen && jump > longint'(cfg_band)) begin
               if (outlier_run != 8'd255) outlier_run++;
               accept = (outlier_run >= need);
            end else begin
               outlier_run = '0;
               accept = 1'b1;
            end
            if (accept) begin
               filt_meas = raw[23:0];
               filt_seen = 1'b1;
               ticks_since_sample = '0;
               if (ctl_enabled && raw >= longint'(cfg_hard_limit)) stop_held = 1'b1;
            end
            r.taken = accept;
         end
         MODE_TICK: begin
            if (ticks_since_sample != 16'hFFFF) ticks_since_sample++;
            if (!ctl_enabled) begin
               r.status = STAT_DISABLED;
               r.force_scale = ONE_Q16;
            end else if (!it.contact_task) begin
               r.status = STAT_INACTIVE;
               r.force_scale = ONE_Q16;
            end else if (!filt_seen || ticks_since_sample > STALE_TICKS) begin
               r.status = STAT_STALE;
            end else if (stop_held) begin
               r.status = STAT_HARD_HOLD;
            end else begin
               f = cfg_full_err;
               p = eff_pause();
               e = longint'(filt_meas) - longint'(cfg_target);
               if (e < 0) e = -e;
               if (e >= p) begin
                  r.status = STAT_ERR_HOLD;
               end else if (e <= f) begin
                  r.status = STAT_TRACKING;
                  r.force_scale = ONE_Q16;
               end else begin
                  // Linear ramp from one at the full-speed error down toward
                  // the floor at the pause error, rounded toward zero.
                  m = (MIN_SCALE < 0) ? 0 :
                      ((MIN_SCALE > longint'(ONE_Q16)) ? longint'(ONE_Q16) : MIN_SCALE);
                  term = (e - f) * (longint'(ONE_Q16) - m) / (p - f);
                  r.status = (term > 0) ? STAT_THROTTLE : STAT_TRACKING;
                  r.force_scale = 17'(longint'(ONE_Q16) - term);
               end
            end
         end
         MODE_TOGGLE: begin
            ctl_enabled = it.enable_value;
            stop_held = 1'b0;
            filt_seen = 1'b0;
            outlier_run = '0;
         end
         default: begin
         end
      endcase
      r.measured = filt_meas;
      r.hard_stop = stop_held;
      return r;
   endfunction

   function automatic int unsigned draw_wait();
      return idle_on ? $urandom_range(0, 17) : 0;
   endfunction

   // Presents one item, waits for the handshake and records its expectation.
   // On return the caller stands at the acceptance edge with valid still high,
   // so a following item without a gap keeps valid up without a glitch.
   task automatic send_item(input force_item_t it, input bit pinned = 1'b0,
                            input throttle_result_t want = '0);
      int unsigned gap;
      throttle_result_t predicted;
      gap = draw_wait();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= it.mode;
      req_bus.force_x <= it.force_x;
      req_bus.force_y <= it.force_y;
      req_bus.force_z <= it.force_z;
      req_bus.contact_task <= it.contact_task;
      req_bus.enable_value <= it.enable_value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = qualify_and_throttle(it);
      pending_results.push_back(pinned ? want : predicted);
      mode_counts[it.mode]++;
      items_sent++;
   endtask

   // Drops valid and waits until every outstanding result has been taken.
   // It always waits on a clock edge before returning, so valid is never lowered and
   // raised again within one time step.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_AXIS_SELECT: cfg_axis = data[1:0];
         CSR_ABSOLUTE_MODE: cfg_magnitude = data[0];
         CSR_SPIKE_BAND: cfg_band = data[22:0];
         CSR_CONFIRM: cfg_confirm = data[7:0];
         CSR_HARD_LIMIT: cfg_hard_limit = data;
         CSR_TARGET_FORCE: cfg_target = data;
         CSR_FULL_SPEED: cfg_full_err = data[22:0];
         CSR_PAUSE_ERROR: cfg_pause_err = data[22:0];
         default: begin
         end
      endcase
   endtask

   // Rewrites every register once the block has gone idle.
   task automatic apply_config(input logic [1:0] axis, input logic magnitude,
                               input logic [22:0] band, input logic [7:0] confirm,
                               input logic signed [23:0] hard, input logic signed [23:0] target,
                               input logic [22:0] full, input logic [22:0] pause);
      wait_drained();
      write_reg(CSR_AXIS_SELECT, 24'(axis));
      write_reg(CSR_ABSOLUTE_MODE, 24'(magnitude));
      write_reg(CSR_SPIKE_BAND, 24'(band));
      write_reg(CSR_CONFIRM, 24'(confirm));
      write_reg(CSR_HARD_LIMIT, hard);
      write_reg(CSR_TARGET_FORCE, target);
      write_reg(CSR_FULL_SPEED, 24'(full));
      write_reg(CSR_PAUSE_ERROR, 24'(pause));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic add_row(input logic [1:0] mode, input logic signed [23:0] fx,
                          input logic signed [23:0] fy, input logic signed [23:0] fz,
                          input logic contact, input logic enable, input bit pinned,
                          input logic [16:0] scale, input logic [2:0] status,
                          input logic signed [23:0] meas, input logic stop,
                          input logic taken);
      directed_row_t row;
      row.item = '{mode, fx, fy, fz, contact, enable};
      row.pinned = pinned;
      row.want = '{scale, status, meas, stop, taken};
      stim_rows.push_back(row);
   endtask

   function automatic force_item_t random_item();
      force_item_t it;
      logic [31:0] rx, ry, rz;
      rx = $urandom();
      ry = $urandom();
      rz = $urandom();
      it.mode = 2'($urandom_range(0, 3));
      it.force_x = rx[23:0];
      it.force_y = ry[23:0];
      it.force_z = rz[23:0];
      it.contact_task = 1'($urandom_range(0, 1));
      it.enable_value = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // A sample item that carries the given force on the selected axis. In
   // magnitude mode the sign is flipped at random, since only |force| counts.
   function automatic force_item_t sample_item(input logic signed [23:0] value);
      force_item_t it;
      it = random_item();
      it.mode = MODE_SAMPLE;
      if (cfg_magnitude && $urandom_range(0, 1) == 1) value = -value;
      case (cfg_axis)
         AXIS_X: it.force_x = value;
         AXIS_Y: it.force_y = value;
         default: it.force_z = value;
      endcase
      return it;
   endfunction

   function automatic force_item_t tick_item(input logic contact);
      force_item_t it;
      it = random_item();
      it.mode = MODE_TICK;
      it.contact_task = contact;
      return it;
   endfunction

   function automatic force_item_t toggle_item(input logic enable);
      force_item_t it;
      it = random_item();
      it.mode = MODE_TOGGLE;
      it.enable_value = enable;
      return it;
   endfunction

   function automatic logic signed [23:0] pick_near(input longint center, input longint spread);
      longint v;
      if (spread > FORCE_TOP) spread = FORCE_TOP;
      v = center + longint'($urandom_range(0, 32'(2 * spread))) - spread;
      if (v > FORCE_TOP) v = FORCE_TOP;
      if (v < FORCE_BOTTOM) v = FORCE_BOTTOM;
      return v[23:0];
   endfunction

   // Random traffic is built from short episodes. Most are well-formed control
   // sequences: enable, then samples around the target or the current force
   // interleaved with contact ticks, which walks the ramp and both holds.
   // The rest are outlier bursts sized around the confirm count, long tick
   // runs that let the sample go stale, raw noise over all modes, and pauses
   // that let the block drain completely.
   task automatic run_phase(input int unsigned count);
      int unsigned stop_at, len, pick, need;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         idle_on = ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            if ($urandom_range(0, 3) == 0) send_item(toggle_item($urandom_range(0, 9) != 0));
            len = $urandom_range(5, 30);
            repeat (len) begin
               if ($urandom_range(0, 1) == 1) begin
                  if ($urandom_range(0, 1) == 1)
                     send_item(sample_item(pick_near(cfg_target, eff_pause() * 3 / 2 + 64)));
                  else
                     send_item(sample_item(pick_near(filt_meas, cfg_band + cfg_band / 4 + 8)));
               end else begin
                  send_item(tick_item($urandom_range(0, 9) != 0));
               end
            end
         end else if (pick < 70) begin
            need = (cfg_confirm == 0) ? 1 : cfg_confirm;
            len = ($urandom_range(0, 1) == 1) ? need + $urandom_range(0, 2) :
                                                $urandom_range(1, need);
            repeat (len) send_item(sample_item(24'($urandom())));
            send_item(tick_item(1'b1));
         end else if (pick < 80) begin
            len = $urandom_range(15, 30);
            repeat (len) send_item(tick_item($urandom_range(0, 9) != 0));
         end else if (pick < 92) begin
            len = $urandom_range(1, 10);
            repeat (len) send_item(random_item());
         end else begin
            wait_drained();
         end
      end
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want_v,
                              input logic signed [63:0] got_v);
      if (want_v !== got_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
         mismatches++;
      end
   endtask

   // Result side: a random hold-off before each result, then ready stays up
   // until a result item is taken and compared with the oldest expectation.
   initial begin : result_sink
      int unsigned gap;
      throttle_result_t want;
      rsp_bus.ready <= 1'b0;
      wait (started);
      forever begin
         gap = draw_wait();
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         status_counts[rsp_bus.status]++;
         if (pending_results.size() == 0) begin
            $error("result item with no expectation waiting (status %0d)", rsp_bus.status);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("force_scale", want.force_scale, rsp_bus.force_scale);
            check_field("status", want.status, rsp_bus.status);
            check_field("measured_out", want.measured, rsp_bus.measured_out);
            check_field("hard_stop_out", want.hard_stop, rsp_bus.hard_stop_out);
            check_field("sample_taken", want.taken, rsp_bus.sample_taken);
         end
      end
   end

   // Ends the run if neither channel completes a handshake for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      wait (started);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("force_spike_filter_progress_throttle_unit test failed");
      $finish;
   end

   initial begin : stimulus
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.mode <= MODE_SAMPLE;
      req_bus.force_x <= '0;
      req_bus.force_y <= '0;
      req_bus.force_z <= '0;
      req_bus.contact_task <= 1'b0;
      req_bus.enable_value <= 1'b0;
      load_reset_state();

      // Directed walk under the reset register values: z axis, magnitude on,
      // band 2048, three outliers to confirm, hard limit 8960, target 3072,
      // full-speed error 512 and pause error 2048. Control starts disabled.
      // A tick right after reset passes at full speed while disabled.
      add_row(MODE_TICK, 0, 0, 0, 1, 0, 1, ONE_Q16, STAT_DISABLED, 0, 0, 0);
      // The unused mode, with every field at an extreme, changes nothing.
      add_row(MODE_SPARE, FORCE_MAX, FORCE_MIN, FORCE_MAX, 1, 1,
              1, 0, STAT_OTHER, 0, 0, 0);
      add_row(MODE_TOGGLE, 0, 0, 0, 0, 1, 1, 0, STAT_OTHER, 0, 0, 0);
      // Enabled but outside a contact task: no throttle.
      add_row(MODE_TICK, 0, 0, 0, 0, 0, 1, ONE_Q16, STAT_INACTIVE, 0, 0, 0);
      // No sample seen yet, so the tick is stale.
      add_row(MODE_TICK, 0, 0, 0, 1, 0, 1, 0, STAT_STALE, 0, 0, 0);
      // The first sample is always accepted; its magnitude is taken.
      add_row(MODE_SAMPLE, FORCE_MIN, FORCE_MAX, -3072, 0, 0,
              1, 0, STAT_OTHER, 3072, 0, 1);
      add_row(MODE_TICK, 0, 0, 0, 1, 0, 1, ONE_Q16, STAT_TRACKING, 3072, 0, 0);
      // A step inside the band, then a tick on the ramp.
      add_row(MODE_SAMPLE, 0, 0, 4072, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_TICK, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
      // The most negative force saturates to the largest magnitude. It is an
      // outlier, held back twice and accepted on the third in a row, which
      // also sets the stop latch while enabled.
      add_row(MODE_SAMPLE, 0, 0, FORCE_MIN, 0, 0, 1, 0, STAT_OTHER, 4072, 0, 0);
      add_row(MODE_SAMPLE, 0, 0, FORCE_MIN, 0, 0, 1, 0, STAT_OTHER, 4072, 0, 0);
      add_row(MODE_SAMPLE, 0, 0, FORCE_MIN, 0, 0, 1, 0, STAT_OTHER, FORCE_MAX, 1, 1);
      add_row(MODE_SAMPLE, 0, 0, FORCE_MAX, 0, 0, 1, 0, STAT_OTHER, FORCE_MAX, 1, 1);
      add_row(MODE_TICK, 0, 0, 0, 1, 0, 1, 0, STAT_HARD_HOLD, FORCE_MAX, 1, 0);
      // A toggle clears the latch and the seen flag but keeps the force.
      add_row(MODE_TOGGLE, 0, 0, 0, 0, 1, 1, 0, STAT_OTHER, FORCE_MAX, 0, 0);
      // Deep on the ramp, near the floor, and then exactly at the pause error.
      add_row(MODE_SAMPLE, 0, 0, 5100, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_TICK, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_SAMPLE, 0, 0, 5120, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_TICK, 0, 0, 0, 1, 0, 1, 0, STAT_ERR_HOLD, 5120, 0, 0);
      // Climbing in band-sized steps up to exactly the hard limit.
      add_row(MODE_SAMPLE, 0, 0, 7000, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(MODE_SAMPLE, 0, 0, 8960, 0, 0, 1, 0, STAT_OTHER, 8960, 1, 1);
      // Disabled: a force above the limit no longer latches.
      add_row(MODE_TOGGLE, 0, 0, 0, 0, 0, 1, 0, STAT_OTHER, 8960, 0, 0);
      add_row(MODE_SAMPLE, 0, 0, 9500, 0, 0, 1, 0, STAT_OTHER, 9500, 0, 1);
      add_row(MODE_TICK, 0, 0, 0, 1, 0, 1, ONE_Q16, STAT_DISABLED, 9500, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      started = 1'b1;

      foreach (stim_rows[i]) send_item(stim_rows[i].item, stim_rows[i].pinned, stim_rows[i].want);

      // Fixed settings that reach the extremes of every register: x axis
      // with signed force; band zero with the largest confirm count so the
      // outlier count saturates; alias axis with the widest band, confirm
      // zero and the lowest limit and target; a ramp across the whole range;
      // and a pause error below the full-speed error.
      apply_config(AXIS_X, 1'b0, 23'd2048, 8'd3, 24'sd8960, 24'sd3072, 23'd512, 23'd2048);
      run_phase(200);
      apply_config(AXIS_Y, 1'b1, 23'd0, 8'd255, FORCE_MAX, 24'sd0, 23'd0, 23'd0);
      run_phase(300);
      apply_config(AXIS_Z_ALIAS, 1'b0, 23'h7FFFFF, 8'd0, FORCE_MIN, FORCE_MIN,
                   23'h7FFFFF, 23'h7FFFFF);
      run_phase(200);
      apply_config(AXIS_Z, 1'b1, 23'd100, 8'd1, 24'sd20000, FORCE_MAX, 23'd1000, 23'h7FFFFF);
      run_phase(200);
      apply_config(AXIS_X, 1'b1, 23'd4096, 8'd2, 24'sd0, 24'sd2000, 23'd300, 23'd200);
      run_phase(150);

      // Random settings, mostly in the range where the ramp is reachable.
      repeat (3) begin
         apply_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 1) == 1) ? 23'($urandom_range(0, 8192)) :
                                                    23'($urandom()),
                      ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 6)) :
                                                    8'($urandom_range(0, 255)),
                      ($urandom_range(0, 1) == 1) ? 24'($urandom_range(0, 20000)) :
                                                    24'($urandom()),
                      24'($urandom_range(0, 12000)),
                      23'($urandom_range(0, 3000)), 23'($urandom_range(0, 6000)));
         run_phase(200);
      end

      // Let the last results arrive, then watch a little longer for strays.
      idle_on = 1'b1;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         mismatches++;
      end

      $display("Ran %0d items (%0d samples, %0d ticks, %0d toggles, %0d spare) over %0d settings.",
               items_sent, mode_counts[MODE_SAMPLE], mode_counts[MODE_TICK],
               mode_counts[MODE_TOGGLE], mode_counts[MODE_SPARE], settings_used + 1);
      $display("Results: %0d disabled, %0d inactive, %0d stale, %0d hard, %0d error, %0d ramp, %0d track.",
               status_counts[STAT_DISABLED], status_counts[STAT_INACTIVE],
               status_counts[STAT_STALE], status_counts[STAT_HARD_HOLD],
               status_counts[STAT_ERR_HOLD], status_counts[STAT_THROTTLE],
               status_counts[STAT_TRACKING]);

      if (mismatches == 0)
         $display("force_spike_filter_progress_throttle_unit test passed");
      else
         $display("force_spike_filter_progress_throttle_unit test failed");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/fspt_pkg.sv
hw/rtl/fspt_req_if.sv
hw/rtl/fspt_rsp_if.sv
hw/rtl/fspt_ctrl.sv
hw/rtl/fspt_datapath.sv
hw/rtl/force_spike_filter_progress_throttle_unit.sv
sim/tb_force_spike_filter_progress_throttle_unit.sv
